FILE: rtl/keyframe_servo_playback_defines.svh
// Assertion macros shared by the keyframe servo playback RTL.
`ifndef KEYFRAME_SERVO_PLAYBACK_DEFINES_SVH
`define KEYFRAME_SERVO_PLAYBACK_DEFINES_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define KSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyframe servo playback check failed");

// The consequent must hold in the cycle after the antecedent.
`define KSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyframe servo playback check failed");

`else

`define KSP_ASSERT_NOW(label, ante, cons)
`define KSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/ksp_pkg.sv
// Types and constants of the keyframe servo playback block.
`timescale 1ns / 1ps
`default_nettype none

package ksp_pkg;

  localparam int SLOT_W = 10;
  localparam int TIME_W = 32;
  localparam int POS_W = 64;
  localparam int CNT_W = 5;
  localparam int SERVO_SEL_W = 4;

  localparam logic [SLOT_W-1:0] FRAME_COUNT_RESET = 10'd1000;

  localparam logic [7:0] BYTE_HEAD0 = 8'hC0;
  localparam logic [7:0] BYTE_HEAD1 = 8'hFF;
  localparam logic [7:0] BYTE_TAIL = 8'hEE;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    opcode_t           opcode;
    logic [SLOT_W-1:0] frame_index;
    logic [TIME_W-1:0] frame_time_us;
    logic [POS_W-1:0]  positions_low;
    logic [POS_W-1:0]  positions_high;
    logic [TIME_W-1:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } ser_t;

endpackage

`default_nettype wire

FILE: rtl/keyframe_servo_playback.sv
// Keyframe servo player: frame table in one memory and a serial byte emitter.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------
//  cmd     | in        | cmd_valid/cmd_stall | ksp_pkg::cmd_t
//  ser     | out       | ser_valid/ser_stall | ksp_pkg::ser_t
//  cfg     | in        | cfg_valid/cfg_ready | frame count, 10 bits
//
// Store, start and stop requests are taken in idle and leave the block idle.
// A tick taken while running registers the table read; the check state then
// compares the elapsed time and returns to idle when no frame is due. A due
// frame then sends SERVO_COUNT + 3 bytes, one per cycle through the output
// register unless the output stalls; cmd_stall is high in check and emit.
// Synchronous reset stops playback; the frame table holds no reset value.
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_servo_playback_defines.svh"

module keyframe_servo_playback #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SERVO_COUNT = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cmd_valid,
  output logic                             cmd_stall,
  input  wire ksp_pkg::cmd_t               cmd,
  output logic                             ser_valid,
  input  wire logic                        ser_stall,
  output ksp_pkg::ser_t                    ser,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ksp_pkg::SLOT_W-1:0]  cfg_frame_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SERVO_W = SERVO_COUNT * 8;
  localparam int ENTRY_W = ksp_pkg::TIME_W + SERVO_W;
  localparam logic [ksp_pkg::CNT_W-1:0] LAST_CNT = ksp_pkg::CNT_W'(SERVO_COUNT + 2);

  ksp_pkg::state_t state, state_next;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_in_range;

  logic [ksp_pkg::SLOT_W-1:0] frame_count;
  logic [ksp_pkg::SLOT_W-1:0] play_index;
  logic [ksp_pkg::TIME_W-1:0] start_time;
  logic [ksp_pkg::TIME_W-1:0] now_r;
  logic                       running;
  logic [ksp_pkg::CNT_W-1:0]  cnt;

  logic                       cmd_take;
  logic                       is_tick;
  logic                       fire;
  logic                       load;
  logic [AW+ksp_pkg::SLOT_W-1:0] play_wide;
  logic [AW+ksp_pkg::SLOT_W-1:0] slot_wide;
  logic [AW-1:0]              play_addr;
  logic [AW-1:0]              slot_addr;
  logic                       play_ok;
  logic                       slot_ok;
  logic [ksp_pkg::TIME_W-1:0] elapsed;
  logic [ksp_pkg::TIME_W-1:0] offs;
  logic [127:0]               pos_full;
  logic [ksp_pkg::CNT_W-1:0]  sel_raw;
  logic [ksp_pkg::SERVO_SEL_W-1:0] sel;
  logic [7:0]                 byte_val;
  logic [ksp_pkg::SLOT_W:0]   index_inc;

  assign cfg_ready = 1'b1;
  assign cmd_take = cmd_valid && !cmd_stall;
  assign is_tick = cmd.opcode == ksp_pkg::OP_TICK;

  assign play_wide = (AW + ksp_pkg::SLOT_W)'(play_index);
  assign slot_wide = (AW + ksp_pkg::SLOT_W)'(cmd.frame_index);
  assign play_addr = play_wide[AW-1:0];
  assign slot_addr = slot_wide[AW-1:0];
  assign play_ok = 32'(play_index) < 32'(TABLE_DEPTH);
  assign slot_ok = 32'(cmd.frame_index) < 32'(TABLE_DEPTH);

  // A slot beyond the table plays as an all-zero frame.
  assign offs = rd_in_range ? rd_data[ENTRY_W-1 -: ksp_pkg::TIME_W] : '0;
  assign pos_full = rd_in_range ? 128'(rd_data[SERVO_W-1:0]) : '0;
  assign elapsed = now_r - start_time;
  assign fire = elapsed > offs;

  assign sel_raw = cnt - ksp_pkg::CNT_W'(2);
  assign sel = sel_raw[ksp_pkg::SERVO_SEL_W-1:0];
  assign index_inc = {1'b0, play_index} + (ksp_pkg::SLOT_W + 1)'(1);

  always_comb begin
    if (cnt == '0) begin
      byte_val = ksp_pkg::BYTE_HEAD0;
    end else if (cnt == ksp_pkg::CNT_W'(1)) begin
      byte_val = ksp_pkg::BYTE_HEAD1;
    end else if (cnt == LAST_CNT) begin
      byte_val = ksp_pkg::BYTE_TAIL;
    end else begin
      byte_val = pos_full[sel*8 +: 8];
    end
  end

  // Frame table: one write port for stores, one registered read for ticks.
  always_ff @(posedge clk) begin
    if (cmd_take && cmd.opcode == ksp_pkg::OP_STORE && slot_ok) begin
      mem[slot_addr] <= {cmd.frame_time_us,
                         SERVO_W'({cmd.positions_high, cmd.positions_low})};
    end
    if (cmd_take && is_tick) begin
      rd_data <= mem[play_addr];
      rd_in_range <= play_ok;
      now_r <= cmd.now_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall = 1'b1;
    load = 1'b0;
    unique case (state)
      ksp_pkg::ST_IDLE: begin
        cmd_stall = 1'b0;
        if (cmd_valid && is_tick && running) begin
          state_next = ksp_pkg::ST_CHECK;
        end
      end
      ksp_pkg::ST_CHECK: begin
        state_next = fire ? ksp_pkg::ST_EMIT : ksp_pkg::ST_IDLE;
      end
      ksp_pkg::ST_EMIT: begin
        load = !ser_valid || !ser_stall;
        if (load && cnt == LAST_CNT) begin
          state_next = ksp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ksp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= ksp_pkg::FRAME_COUNT_RESET;
      play_index <= '0;
      start_time <= '0;
      running <= 1'b0;
      cnt <= '0;
      ser_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_count <= cfg_frame_count;
      end
      if (cmd_take) begin
        case (cmd.opcode)
          ksp_pkg::OP_START: begin
            play_index <= '0;
            start_time <= cmd.now_us;
            running <= 1'b1;
          end
          ksp_pkg::OP_STOP: begin
            running <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      // The frame data is already held in rd_data, so the index moves on now.
      if (state == ksp_pkg::ST_CHECK && fire) begin
        cnt <= '0;
        if (index_inc >= {1'b0, frame_count}) begin
          play_index <= '0;
          start_time <= now_r;
        end else begin
          play_index <= index_inc[ksp_pkg::SLOT_W-1:0];
        end
      end
      if (load) begin
        ser_valid <= 1'b1;
        cnt <= cnt + ksp_pkg::CNT_W'(1);
      end else if (ser_valid && !ser_stall) begin
        ser_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ser.out_byte <= byte_val;
      ser.last_byte <= cnt == LAST_CNT;
    end
  end

  `KSP_ASSERT_NEXT(a_fire_starts_emit, state == ksp_pkg::ST_CHECK && fire,
                   state == ksp_pkg::ST_EMIT && cnt == '0)
  `KSP_ASSERT_NEXT(a_last_load_ends, load && cnt == LAST_CNT,
                   state == ksp_pkg::ST_IDLE && ser_valid && ser.last_byte)
  `KSP_ASSERT_NOW(a_last_is_tail, ser_valid && ser.last_byte,
                  ser.out_byte == ksp_pkg::BYTE_TAIL)
  `KSP_ASSERT_NEXT(a_idle_tick_quiet, cmd_take && is_tick && !running,
                   state == ksp_pkg::ST_IDLE)

endmodule

`default_nettype wire

FILE: tb/keyframe_servo_playback_checker.sv
// Checker that predicts the serial bytes of the keyframe servo playback block and compares them.
`timescale 1ns / 1ps

module keyframe_servo_playback_checker #(
  parameter int SERVO_COUNT = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  input  logic                         cmd_stall,
  input  ksp_pkg::cmd_t                cmd,
  input  logic                         ser_valid,
  input  logic                         ser_stall,
  input  ksp_pkg::ser_t                ser,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ksp_pkg::SLOT_W-1:0]   cfg_frame_count,
  output int                           mismatches,
  output int                           pending,
  output int                           bytes_checked,
  output int                           frames_checked
);
  import ksp_pkg::*;

  logic [TIME_W-1:0] key_time     [1024];
  logic [POS_W-1:0]  key_pos_low  [1024];
  logic [POS_W-1:0]  key_pos_high [1024];
  logic [SLOT_W-1:0] play_slot;
  logic [TIME_W-1:0] play_origin;
  logic              playing;
  logic [SLOT_W-1:0] frames_per_loop;
  ser_t              due_bytes [$];
  ser_t              got_byte;
  ser_t              want_byte;
  int                fail_total = 0;
  int                byte_total = 0;
  int                frame_total = 0;

  function automatic ser_t serial_byte(input logic [7:0] value, input logic last);
    ser_t b;
    b.out_byte = value;
    b.last_byte = last;
    return b;
  endfunction

  task automatic flag_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("MISMATCH: %s", msg);
  endtask

  // Applies one accepted request to the predicted state and queues the bytes it emits.
  task automatic advance_playback(input cmd_t c);
    logic [TIME_W-1:0]  elapsed;
    logic [2*POS_W-1:0] servo_bytes;
    logic [SLOT_W:0]    next_slot;
    int                 s;
    case (c.opcode)
      OP_STORE: begin
        key_time[c.frame_index] = c.frame_time_us;
        key_pos_low[c.frame_index] = c.positions_low;
        key_pos_high[c.frame_index] = c.positions_high;
      end
      OP_START: begin
        play_slot = '0;
        play_origin = c.now_us;
        playing = 1'b1;
      end
      OP_STOP: begin
        playing = 1'b0;
      end
      OP_TICK: begin
        // Elapsed time wraps modulo 2^32 and must strictly exceed the frame offset.
        elapsed = c.now_us - play_origin;
        if (playing && elapsed > key_time[play_slot]) begin
          servo_bytes = {key_pos_high[play_slot], key_pos_low[play_slot]};
          due_bytes.push_back(serial_byte(BYTE_HEAD0, 1'b0));
          due_bytes.push_back(serial_byte(BYTE_HEAD1, 1'b0));
          for (s = 0; s < SERVO_COUNT; s++)
            due_bytes.push_back(serial_byte(servo_bytes[8*s +: 8], 1'b0));
          due_bytes.push_back(serial_byte(BYTE_TAIL, 1'b1));
          next_slot = {1'b0, play_slot} + 1'b1;
          if (next_slot >= {1'b0, frames_per_loop}) begin
            play_slot = '0;
            play_origin = c.now_us;
          end else begin
            play_slot = next_slot[SLOT_W-1:0];
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      play_slot = '0;
      play_origin = '0;
      playing = 1'b0;
      frames_per_loop = FRAME_COUNT_RESET;
      due_bytes.delete();
    end else begin
      if (ser_valid && !ser_stall) begin
        got_byte = ser;
        byte_total++;
        if (got_byte.last_byte === 1'b1) frame_total++;
        if (due_bytes.size() == 0) begin
          flag_failure($sformatf("byte %02h last %0b arrived with nothing expected",
                                 got_byte.out_byte, got_byte.last_byte));
        end else begin
          want_byte = due_bytes.pop_front();
          if (got_byte.out_byte !== want_byte.out_byte ||
              got_byte.last_byte !== want_byte.last_byte) begin
            flag_failure($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                   byte_total, want_byte.out_byte, want_byte.last_byte,
                                   got_byte.out_byte, got_byte.last_byte));
          end
        end
      end
      if (cfg_valid && cfg_ready) frames_per_loop = cfg_frame_count;
      if (cmd_valid && !cmd_stall) advance_playback(cmd);
    end
    mismatches <= fail_total;
    pending <= due_bytes.size();
    bytes_checked <= byte_total;
    frames_checked <= frame_total;
  end

endmodule

FILE: tb/keyframe_servo_playback_tb.sv
// Testbench top for the keyframe servo playback block: stimulus, output pacing and verdict.
`timescale 1ns / 1ps

module keyframe_servo_playback_tb;
  import ksp_pkg::*;

  localparam int ITEM_TARGET = 220;
  localparam int PHASE_ITEMS = 25;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  cmd_t              cmd = '0;
  logic              ser_valid;
  logic              ser_stall = 1'b0;
  ser_t              ser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SLOT_W-1:0] cfg_frame_count = '0;

  int mismatches;
  int pending;
  int bytes_checked;
  int frames_checked;
  int hold_seq = 0;
  int cycle_count = 0;

  // Stimulus bookkeeping: which slots hold data and how far playback may have advanced.
  logic [TIME_W-1:0] cur_now = '0;
  bit                slot_written [1024];
  int                written_prefix = 0;
  int                frame_limit = FRAME_COUNT_RESET;
  int                slot_bound = 0;
  bit                running = 1'b0;
  bit                no_gaps = 1'b0;
  int                items_sent = 0;
  int                settings_used = 0;

  keyframe_servo_playback #(
    .TABLE_DEPTH(1024),
    .SERVO_COUNT(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .ser_valid(ser_valid),
    .ser_stall(ser_stall),
    .ser(ser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_frame_count(cfg_frame_count)
  );

  keyframe_servo_playback_checker #(
    .SERVO_COUNT(16)
  ) playback_check (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .ser_valid(ser_valid),
    .ser_stall(ser_stall),
    .ser(ser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_frame_count(cfg_frame_count),
    .mismatches(mismatches),
    .pending(pending),
    .bytes_checked(bytes_checked),
    .frames_checked(frames_checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d bytes outstanding.", cycle_count, pending);
      $display("keyframe_servo_playback_tb: FAIL");
      $finish;
    end
  end

  // Output side: random stall runs, plus one long hold when the stimulus asks for it.
  initial begin
    int hold_done;
    int r;
    hold_done = 0;
    forever begin
      if (hold_seq != hold_done) begin
        ser_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_seq;
      end else begin
        r = $urandom_range(99);
        if (r < 60) begin
          ser_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end else if (r < 88) begin
          ser_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (r < 95) begin
          ser_stall <= 1'b0;
          repeat ($urandom_range(40, 120)) @(posedge clk);
        end else begin
          ser_stall <= 1'b1;
          repeat ($urandom_range(15, 50)) @(posedge clk);
        end
      end
    end
  end

  function automatic cmd_t random_request(input opcode_t op);
    cmd_t c;
    c.opcode = op;
    c.frame_index = $urandom_range(1023);
    c.frame_time_us = $urandom;
    c.positions_low = {$urandom, $urandom};
    c.positions_high = {$urandom, $urandom};
    c.now_us = $urandom;
    return c;
  endfunction

  // Presents one request and returns at the edge that accepts it, then idles at random.
  task automatic send_request(input cmd_t c);
    int n;
    int r;
    if (c.opcode == OP_STORE || c.opcode == OP_START || running) items_sent++;
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    r = $urandom_range(99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 96) n = $urandom_range(4, 12);
    else n = $urandom_range(25, 60);
    if (n > 0) begin
      cmd_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // A tick that fires nothing may still be in the compare stage.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame_count(input int count);
    cfg_frame_count <= count[SLOT_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_limit = count;
    settings_used++;
  endtask

  task automatic store_frame(input int slot, input logic [TIME_W-1:0] offset,
                             input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
    cmd_t c;
    c = random_request(OP_STORE);
    c.frame_index = slot[SLOT_W-1:0];
    c.frame_time_us = offset;
    c.positions_low = lo;
    c.positions_high = hi;
    send_request(c);
    slot_written[slot] = 1'b1;
    while (written_prefix < 1024 && slot_written[written_prefix]) written_prefix++;
  endtask

  task automatic start_playback(input logic [TIME_W-1:0] at_us);
    cmd_t c;
    c = random_request(OP_START);
    c.now_us = at_us;
    send_request(c);
    running = 1'b1;
    slot_bound = 0;
    cur_now = at_us;
  endtask

  task automatic stop_playback();
    send_request(random_request(OP_STOP));
    running = 1'b0;
  endtask

  task automatic play_tick(input logic [TIME_W-1:0] at_us);
    cmd_t c;
    if (running && slot_bound >= written_prefix) begin
      // Playback may have reached a slot that holds nothing yet: fill it first.
      store_frame(written_prefix, $urandom_range(80), {$urandom, $urandom},
                  {$urandom, $urandom});
    end else begin
      cur_now = at_us;
      c = random_request(OP_TICK);
      c.now_us = at_us;
      send_request(c);
      if (running && slot_bound + 1 < frame_limit) slot_bound++;
    end
  endtask

  initial begin
    int r;
    int phase;
    int phase_end;
    int phase_counts [8];
    phase_counts = '{2, 1023, 0, 7, 1, 1000, 4, 3};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests, starting from the reset frame count.
    play_tick(32'h0000_1234);
    stop_playback();
    store_frame(0, 32'd0, '0, '0);
    store_frame(1, 32'd5, '1, '1);
    store_frame(2, 32'd20, 64'h0706_0504_0302_0100, 64'h0F0E_0D0C_0B0A_0908);
    store_frame(3, 32'd40, {$urandom, $urandom}, {$urandom, $urandom});
    store_frame(1023, 32'hFFFF_FFFF, {$urandom, $urandom}, {$urandom, $urandom});
    start_playback(32'hFFFF_FFF0);
    play_tick(32'hFFFF_FFF0);
    play_tick(32'hFFFF_FFF1);
    play_tick(32'hFFFF_FFF5);
    play_tick(32'h0000_0002);
    store_frame(4, 32'd60, {$urandom, $urandom}, {$urandom, $urandom});
    play_tick(32'h0000_0010);
    start_playback(32'd100);
    play_tick(32'd101);
    stop_playback();
    play_tick(32'd500);
    wait_idle();
    set_frame_count(0);
    start_playback(32'd1000);
    play_tick(32'd1001);
    play_tick(32'd1002);
    wait_idle();
    set_frame_count(3);
    start_playback(32'd2000);
    play_tick(32'd2100);
    play_tick(32'd2200);
    // Lower the frame count below the current play index.
    wait_idle();
    set_frame_count(1);
    play_tick(32'd2300);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      set_frame_count(phase < 8 ? phase_counts[phase] : $urandom_range(1023));
      no_gaps = (phase % 3 == 2);
      if (phase == 1) hold_seq <= hold_seq + 1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < ITEM_TARGET) begin
        r = $urandom_range(99);
        if (r < 10) begin
          start_playback($urandom_range(1) ? $urandom : cur_now + $urandom_range(100));
        end else if (r < 15) begin
          stop_playback();
        end else if (r < 33) begin
          if ($urandom_range(99) < 60)
            store_frame($urandom_range(0, written_prefix < 1023 ? written_prefix : 1023),
                        $urandom_range(80), {$urandom, $urandom}, {$urandom, $urandom});
          else
            store_frame($urandom_range(512, 1023), $urandom, {$urandom, $urandom},
                        {$urandom, $urandom});
        end else if (!running && $urandom_range(99) < 70) begin
          start_playback(cur_now + $urandom_range(100));
        end else begin
          play_tick(cur_now + ($urandom_range(9) == 0 ? $urandom : $urandom_range(60)));
        end
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d requests over %0d frame-count settings (0 and 1023 among them),",
             items_sent, settings_used);
    $display("with stalls on both sides and one long output hold; %0d bytes in %0d frames.",
             bytes_checked, frames_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("keyframe_servo_playback_tb: PASS");
    end else begin
      $display("keyframe_servo_playback_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: keyframe_servo_playback.f
+incdir+rtl
rtl/ksp_pkg.sv
rtl/keyframe_servo_playback.sv
tb/keyframe_servo_playback_checker.sv
tb/keyframe_servo_playback_tb.sv
